// ===== rtl/stt_pkg.sv =====
`default_nettype none

package stt_pkg;

    // Field widths
    localparam int AMP_W      = 24;
    localparam int STEP_W     = 23;
    localparam int CNT_W      = 14;
    localparam int SPK_W      = 10;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Step rounding divider: dividend is step + 2*final - 1
    localparam int DIV_W     = STEP_W + 2;
    localparam int REM_W     = STEP_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [AMP_W-1:0] AMP_MAX = {1'b0, {(AMP_W-1){1'b1}}};
    localparam logic [AMP_W-1:0] AMP_MIN = {1'b1, {(AMP_W-1){1'b0}}};

    // Register reset values
    localparam logic [AMP_W-1:0]  RST_START_AMP    = '0;
    localparam logic [STEP_W-1:0] RST_START_STEP   = STEP_W'(100);
    localparam logic [STEP_W-1:0] RST_FINAL_STEP   = STEP_W'(10);
    localparam logic [SPK_W-1:0]  RST_MIN_SPIKES   = SPK_W'(1);
    localparam logic [CNT_W-1:0]  RST_REPEAT_LIMIT = CNT_W'(10);

    // Item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TRIAL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_AMP    = 3'd0,
        REG_START_STEP   = 3'd1,
        REG_FINAL_STEP   = 3'd2,
        REG_MIN_SPIKES   = 3'd3,
        REG_REPEAT_LIMIT = 3'd4
    } t_reg_idx;

    typedef enum logic [PHASE_W-1:0] {
        PH_SEARCH  = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_RECORD  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic update;
        logic div_init;
        logic div_step;
        logic div_commit;
        logic load_out;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [AMP_W-1:0]   next_amplitude;
        logic [STEP_W-1:0]  step_size;
        logic [PHASE_W-1:0] phase;
        logic [CNT_W-1:0]   trial_number;
        logic [CNT_W-1:0]   spiking_trials;
        logic               finished;
        logic               bad_setup;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/stt_if.sv =====
`default_nettype none

// Trial / start item channel
interface stt_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [stt_pkg::SPK_W-1:0] spike_count;

    modport source (output valid, kind, spike_count, input ready);
    modport sink   (input valid, kind, spike_count, output ready);
endinterface

// Result channel
interface stt_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [stt_pkg::AMP_W-1:0]   next_amplitude;
    logic        [stt_pkg::STEP_W-1:0]  step_size;
    logic        [stt_pkg::PHASE_W-1:0] phase;
    logic        [stt_pkg::CNT_W-1:0]   trial_number;
    logic        [stt_pkg::CNT_W-1:0]   spiking_trials;
    logic                               finished;
    logic                               bad_setup;

    modport source (output valid, next_amplitude, step_size, phase, trial_number,
                    spiking_trials, finished, bad_setup, input ready);
    modport sink   (input valid, next_amplitude, step_size, phase, trial_number,
                    spiking_trials, finished, bad_setup, output ready);
endinterface

// Register write channel
interface stt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [stt_pkg::CFG_IDX_W-1:0]  index;
    logic [stt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/stt_ctrl.sv =====
`default_nettype none

module stt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output stt_pkg::t_cmd       o_cmd,
    input  wire stt_pkg::t_stat i_stat
);

    stt_pkg::t_state r_state;
    stt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            stt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = stt_pkg::ST_EXEC;
                end
            end
            stt_pkg::ST_EXEC: begin
                o_cmd.update = 1'b1;
                if (i_stat.need_div) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = stt_pkg::ST_DIV;
                end else begin
                    n_state = stt_pkg::ST_OUT;
                end
            end
            stt_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = stt_pkg::ST_FIN;
                end
            end
            stt_pkg::ST_FIN: begin
                o_cmd.div_commit = 1'b1;
                n_state          = stt_pkg::ST_OUT;
            end
            stt_pkg::ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = stt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/stt_dp.sv =====
`default_nettype none

module stt_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire stt_pkg::t_cmd             i_cmd,
    output stt_pkg::t_stat                 o_stat,
    input  wire stt_pkg::t_cfg_wr          i_cfg,
    input  wire logic                      i_kind,
    input  wire logic [stt_pkg::SPK_W-1:0] i_spike_count,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output stt_pkg::t_result               o_result
);

    // Configuration
    logic [stt_pkg::AMP_W-1:0]  r_start_amp;
    logic [stt_pkg::STEP_W-1:0] r_start_step;
    logic [stt_pkg::STEP_W-1:0] r_final_step;
    logic [stt_pkg::SPK_W-1:0]  r_min_spikes;
    logic [stt_pkg::CNT_W-1:0]  r_repeat_limit;

    // Captured item
    logic                      r_kind;
    logic [stt_pkg::SPK_W-1:0] r_count;

    // Tracker state
    logic [stt_pkg::AMP_W-1:0]  r_amp,        n_amp;
    logic [stt_pkg::STEP_W-1:0] r_step,       n_step;
    stt_pkg::t_phase            r_mode,       n_mode;
    logic                       r_last_above, n_last_above;
    logic                       r_have_last,  n_have_last;
    logic [stt_pkg::CNT_W-1:0]  r_trials,     n_trials;
    logic [stt_pkg::CNT_W-1:0]  r_spiking,    n_spiking;
    logic                       r_done,       n_done;
    logic                       r_error,      n_error;

    // Divider
    logic [stt_pkg::REM_W-1:0]     r_rem;
    logic [stt_pkg::DIV_W-1:0]     r_quo_sh;
    logic [stt_pkg::DIV_CNT_W-1:0] r_div_cnt;

    // Output register
    logic             r_out_valid;
    stt_pkg::t_result r_result;

    logic                       above;
    logic                       run;
    logic                       reversal;
    logic                       step_le_final;
    logic                       final_zero;
    logic [stt_pkg::CNT_W-1:0]  trials_inc;
    logic [stt_pkg::CNT_W-1:0]  spiking_inc;
    logic [stt_pkg::AMP_W:0]    amp_ext;
    logic [stt_pkg::AMP_W:0]    step_ext;
    logic [stt_pkg::AMP_W:0]    amp_sum;
    logic [stt_pkg::AMP_W-1:0]  amp_sat;
    logic [stt_pkg::REM_W-1:0]  q2;
    logic [stt_pkg::DIV_W-1:0]  div_num;
    logic [stt_pkg::DIV_W-1:0]  div_shift;
    logic [stt_pkg::DIV_W-1:0]  div_sub;
    logic [stt_pkg::DIV_W-1:0]  div_diff;

    assign above         = r_count >= r_min_spikes;
    assign run           = (r_kind == stt_pkg::KIND_TRIAL) && !r_done && !r_error;
    assign reversal      = (r_mode != stt_pkg::PH_RECORD) && r_have_last
                           && (r_last_above != above);
    assign step_le_final = r_step <= r_final_step;
    assign final_zero    = r_final_step == '0;

    assign trials_inc  = (&r_trials) ? r_trials : r_trials + stt_pkg::CNT_W'(1);
    assign spiking_inc = (r_count == '0) ? r_spiking
                       : ((&r_spiking) ? r_spiking : r_spiking + stt_pkg::CNT_W'(1));

    // Saturating amplitude move
    assign amp_ext  = {r_amp[stt_pkg::AMP_W-1], r_amp};
    assign step_ext = (stt_pkg::AMP_W+1)'(r_step);
    assign amp_sum  = above ? amp_ext - step_ext : amp_ext + step_ext;
    always_comb begin
        if (amp_sum[stt_pkg::AMP_W] != amp_sum[stt_pkg::AMP_W-1]) begin
            amp_sat = amp_sum[stt_pkg::AMP_W] ? stt_pkg::AMP_MIN : stt_pkg::AMP_MAX;
        end else begin
            amp_sat = amp_sum[stt_pkg::AMP_W-1:0];
        end
    end

    // ceil(step / 2f) * f == (D - D mod 2f) / 2 with D = step + 2f - 1
    assign q2        = {r_final_step, 1'b0};
    assign div_num   = stt_pkg::DIV_W'(r_step) + stt_pkg::DIV_W'(q2)
                     - stt_pkg::DIV_W'(1);
    assign div_shift = {r_rem, r_quo_sh[stt_pkg::DIV_W-1]};
    assign div_sub   = (div_shift >= stt_pkg::DIV_W'(q2))
                     ? div_shift - stt_pkg::DIV_W'(q2) : div_shift;
    assign div_diff  = div_num - stt_pkg::DIV_W'(r_rem);

    assign o_stat.need_div = run && reversal && !step_le_final && !final_zero;
    assign o_stat.div_last = r_div_cnt == stt_pkg::DIV_CNT_W'(stt_pkg::DIV_W - 1);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        logic [stt_pkg::CNT_W-1:0] t;
        logic [stt_pkg::CNT_W-1:0] s;
        stt_pkg::t_phase           m;
        logic                      adv;

        t   = trials_inc;
        s   = spiking_inc;
        m   = r_mode;
        adv = 1'b0;

        n_amp        = r_amp;
        n_step       = r_step;
        n_mode       = r_mode;
        n_last_above = r_last_above;
        n_have_last  = r_have_last;
        n_trials     = r_trials;
        n_spiking    = r_spiking;
        n_done       = r_done;
        n_error      = r_error;

        if (i_cmd.update) begin
            if (r_kind == stt_pkg::KIND_START) begin
                n_amp        = r_start_amp;
                n_step       = r_start_step;
                n_mode       = stt_pkg::PH_SEARCH;
                n_last_above = 1'b0;
                n_have_last  = 1'b0;
                n_trials     = '0;
                n_spiking    = '0;
                n_done       = 1'b0;
                n_error      = r_start_step < r_final_step;
            end else if (run) begin
                n_amp = amp_sat;
                if (reversal) begin
                    if (step_le_final) begin
                        n_step = r_final_step;
                        m      = (r_mode == stt_pkg::PH_SEARCH) ? stt_pkg::PH_CONFIRM
                                                              : stt_pkg::PH_RECORD;
                        t      = '0;
                        s      = '0;
                        adv    = 1'b1;
                    end else if (final_zero) begin
                        n_step = '0;
                    end
                    // otherwise the divider rewrites the step
                end
                n_have_last  = !adv;
                n_last_above = adv ? 1'b0 : above;
                n_trials     = t;
                n_spiking    = s;
                n_mode       = m;
                if ((m == stt_pkg::PH_RECORD) && (r_repeat_limit != '0)
                    && (t >= r_repeat_limit)) begin
                    n_done = 1'b1;
                end
            end
        end

        if (i_cmd.div_commit) begin
            n_step = div_diff[stt_pkg::STEP_W:1];
        end
    end

    // Control and tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_amp    <= stt_pkg::RST_START_AMP;
            r_start_step   <= stt_pkg::RST_START_STEP;
            r_final_step   <= stt_pkg::RST_FINAL_STEP;
            r_min_spikes   <= stt_pkg::RST_MIN_SPIKES;
            r_repeat_limit <= stt_pkg::RST_REPEAT_LIMIT;
            r_amp          <= '0;
            r_step         <= '0;
            r_mode         <= stt_pkg::PH_SEARCH;
            r_last_above   <= 1'b0;
            r_have_last    <= 1'b0;
            r_trials       <= '0;
            r_spiking      <= '0;
            r_done         <= 1'b0;
            r_error        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (stt_pkg::t_reg_idx'(i_cfg.index))
                    stt_pkg::REG_START_AMP:
                        r_start_amp <= i_cfg.data[stt_pkg::AMP_W-1:0];
                    stt_pkg::REG_START_STEP:
                        r_start_step <= i_cfg.data[stt_pkg::STEP_W-1:0];
                    stt_pkg::REG_FINAL_STEP:
                        r_final_step <= i_cfg.data[stt_pkg::STEP_W-1:0];
                    stt_pkg::REG_MIN_SPIKES:
                        r_min_spikes <= i_cfg.data[stt_pkg::SPK_W-1:0];
                    stt_pkg::REG_REPEAT_LIMIT:
                        r_repeat_limit <= i_cfg.data[stt_pkg::CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_amp        <= n_amp;
            r_step       <= n_step;
            r_mode       <= n_mode;
            r_last_above <= n_last_above;
            r_have_last  <= n_have_last;
            r_trials     <= n_trials;
            r_spiking    <= n_spiking;
            r_done       <= n_done;
            r_error      <= n_error;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: item capture, divider, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_count <= i_spike_count;
        end
        if (i_cmd.div_init) begin
            r_rem     <= '0;
            r_quo_sh  <= div_num;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= div_sub[stt_pkg::REM_W-1:0];
            r_quo_sh  <= {r_quo_sh[stt_pkg::DIV_W-2:0], 1'b0};
            r_div_cnt <= r_div_cnt + stt_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.load_out) begin
            r_result.next_amplitude <= r_amp;
            r_result.step_size      <= r_step;
            r_result.phase          <= r_mode;
            r_result.trial_number   <= r_trials;
            r_result.spiking_trials <= r_spiking;
            r_result.finished       <= r_done;
            r_result.bad_setup      <= r_error;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

// ===== rtl/staircase_threshold_tracker_top.sv =====
`default_nettype none

// Channel    Dir  Beat contents                                  Accepted when
// i_trial    in   kind, spike_count                              valid && ready
// o_result   out  next_amplitude, step_size, phase, trial_number, valid && ready
//                 spiking_trials, finished, bad_setup
// i_cfg      in   index, data (register write)                   valid && ready
//
// Each input beat yields exactly one result beat. No new beat is accepted
// until its result is loaded; when a reversal refines the step, the
// one-bit-per-cycle restoring divider runs before that load.
// i_cfg.ready is always high; writes take effect on the next cycle.
// Reset is synchronous, active low, and restores register defaults.
// A result waiting on o_result does not block the next input beat; only
// the following result waits for the output register to drain.

module staircase_threshold_tracker_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stt_in_if.sink     i_trial,
    stt_out_if.source  o_result,
    stt_cfg_if.sink    i_cfg
);

    stt_pkg::t_cmd    cmd;
    stt_pkg::t_stat   stat;
    stt_pkg::t_cfg_wr cfg_wr;
    stt_pkg::t_result result;
    logic             in_ready;
    logic             out_valid;

    // Register writes are never back-pressured
    assign i_cfg.ready  = 1'b1;
    assign cfg_wr.valid = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    // Sequencer: accept, update, optional step division, result load
    stt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_trial.valid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // Registers, tracker state, divider and output register
    stt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg         (cfg_wr),
        .i_kind        (i_trial.kind),
        .i_spike_count (i_trial.spike_count),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (out_valid),
        .o_result      (result)
    );

    assign i_trial.ready = in_ready;

    assign o_result.valid          = out_valid;
    assign o_result.next_amplitude = result.next_amplitude;
    assign o_result.step_size      = result.step_size;
    assign o_result.phase          = result.phase;
    assign o_result.trial_number   = result.trial_number;
    assign o_result.spiking_trials = result.spiking_trials;
    assign o_result.finished       = result.finished;
    assign o_result.bad_setup      = result.bad_setup;

endmodule

`default_nettype wire

// ===== rtl/stt_checker.sv =====
`default_nettype none

module stt_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [stt_pkg::PHASE_W-1:0] i_out_phase,
    input wire logic                        i_out_finished,
    input wire logic                        i_out_bad_setup
);

    // A result beat stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped while stalled");

    // One item in flight: the cycle after an accept the block is busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted on consecutive cycles");

    // A bad setup halts the search, so it never finishes
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_finished && i_out_bad_setup))
        else $error("finished and bad_setup both set");

    // Finishing only happens in the record phase
    a_finished_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_finished |-> i_out_phase == stt_pkg::PH_RECORD)
        else $error("finished outside record phase");

endmodule

bind staircase_threshold_tracker_top stt_checker u_stt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_trial.valid),
    .i_in_ready      (i_trial.ready),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_out_phase     (o_result.phase),
    .i_out_finished  (o_result.finished),
    .i_out_bad_setup (o_result.bad_setup)
);

`default_nettype wire

// ===== dv/tb_staircase_threshold_tracker_top.sv =====
module tb_staircase_threshold_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 850;
    localparam int IDLE_PCT      = 9;       // idle odds per cycle, both sides
    localparam int QUIET_FROM    = 300;     // random beats with no idling at all
    localparam int QUIET_TO      = 450;
    localparam int REPORT_MAX    = 10;
    localparam int DRAIN_CYCLES  = 60;      // quiet time after the last result
    localparam int CYCLE_LIMIT   = 500000;  // covers every beat plus stalls, many times over

    localparam logic [STEP_W-1:0]    STEP_MAX = '1;
    localparam logic [SPK_W-1:0]     SPK_MAX  = '1;
    localparam logic [CNT_W-1:0]     CNT_MAX  = '1;
    localparam logic [CFG_IDX_W-1:0] IDX_TOP  = '1;

    // Directed plan: register writes and beats, some with a hand-typed result
    typedef enum logic {ROW_REG, ROW_BEAT} t_row_op;

    typedef struct {
        t_row_op               op;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  kind;
        logic [SPK_W-1:0]      spikes;
        bit                    typed;
        t_result               want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    stt_in_if  trial_if ();
    stt_out_if result_if ();
    stt_cfg_if cfg_if ();

    staircase_threshold_tracker_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_trial  (trial_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Register shadow
    logic signed [AMP_W-1:0] cfg_start_amp;
    logic [STEP_W-1:0]       cfg_start_step;
    logic [STEP_W-1:0]       cfg_final_step;
    logic [SPK_W-1:0]        cfg_min_spikes;
    logic [CNT_W-1:0]        cfg_repeat_limit;

    // Staircase state as the tracker should hold it
    logic signed [AMP_W-1:0] trk_amp;
    logic [STEP_W-1:0]       trk_step;
    t_phase                  trk_phase;
    logic                    trk_last_above;
    logic                    trk_have_last;
    logic [CNT_W-1:0]        trk_trials;
    logic [CNT_W-1:0]        trk_spiking;
    logic                    trk_done;
    logic                    trk_bad;

    t_result     expected_q[$];
    t_row        plan[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          beats_sent = 0;
    int          rand_base = 0;
    bit          rand_on = 1'b0;
    bit          hush = 1'b0;      // no idling on either side while set

    function automatic logic signed [AMP_W-1:0] clamp_amp(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (AMP_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return AMP_W'(hi);
        if (v < lo) return AMP_W'(lo);
        return AMP_W'(v);
    endfunction

    function automatic logic [CNT_W-1:0] bump_count(logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    // Advance the staircase by one beat and return the result it must report
    function automatic t_result track_beat(logic kind, logic [SPK_W-1:0] spikes);
        t_result r;
        logic    above;
        logic    advance;
        longint  q2;
        longint  n;
        if (kind == KIND_START) begin
            trk_amp        = clamp_amp(longint'(cfg_start_amp));
            trk_step       = cfg_start_step;
            trk_phase      = PH_SEARCH;
            trk_have_last  = 1'b0;
            trk_last_above = 1'b0;
            trk_trials     = '0;
            trk_spiking    = '0;
            trk_done       = 1'b0;
            trk_bad        = cfg_start_step < cfg_final_step;
        end else if (!trk_done && !trk_bad) begin
            above      = spikes >= cfg_min_spikes;
            trk_trials = bump_count(trk_trials);
            // spiking counts any spike, not the suprathreshold test
            if (spikes != '0) trk_spiking = bump_count(trk_spiking);
            trk_amp = clamp_amp(above ? longint'(trk_amp) - longint'(trk_step)
                                      : longint'(trk_amp) + longint'(trk_step));
            advance = 1'b0;
            if (trk_phase != PH_RECORD && trk_have_last && trk_last_above != above) begin
                if (trk_step <= cfg_final_step) begin
                    trk_step    = cfg_final_step;
                    trk_phase   = t_phase'(trk_phase + 1'b1);
                    trk_trials  = '0;
                    trk_spiking = '0;
                    advance     = 1'b1;
                end else if (cfg_final_step == '0) begin
                    trk_step = '0;
                end else begin
                    // ceil(step / (2*final)) * final
                    q2       = 2 * longint'(cfg_final_step);
                    n        = (longint'(trk_step) + q2 - 1) / q2;
                    trk_step = STEP_W'(n * longint'(cfg_final_step));
                end
            end
            trk_have_last  = !advance;
            trk_last_above = advance ? 1'b0 : above;
            if (trk_phase == PH_RECORD && cfg_repeat_limit != '0
                    && trk_trials >= cfg_repeat_limit)
                trk_done = 1'b1;
        end
        r.next_amplitude = trk_amp;
        r.step_size      = trk_step;
        r.phase          = trk_phase;
        r.trial_number   = trk_trials;
        r.spiking_trials = trk_spiking;
        r.finished       = trk_done;
        r.bad_setup      = trk_bad;
        return r;
    endfunction

    function automatic t_result result_of(logic [AMP_W-1:0] amp, logic [STEP_W-1:0] step,
                                          t_phase ph, logic [CNT_W-1:0] trials,
                                          logic [CNT_W-1:0] spiking, logic fin, logic bad);
        t_result r;
        r.next_amplitude = amp;
        r.step_size      = step;
        r.phase          = ph;
        r.trial_number   = trials;
        r.spiking_trials = spiking;
        r.finished       = fin;
        r.bad_setup      = bad;
        return r;
    endfunction

    function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row row;
        row.op     = ROW_REG;
        row.idx    = idx;
        row.data   = data;
        row.kind   = KIND_START;
        row.spikes = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        plan.insert(plan.size(), row);
    endfunction

    function automatic void plan_beat(logic kind, logic [SPK_W-1:0] spikes,
                                      bit typed = 1'b0, t_result want = '0);
        t_row row;
        row.op     = ROW_BEAT;
        row.idx    = '0;
        row.data   = '0;
        row.kind   = kind;
        row.spikes = spikes;
        row.typed  = typed;
        row.want   = want;
        plan.insert(plan.size(), row);
    endfunction

    // Random junk above a narrow register's width; the tracker must drop it
    function automatic logic [CFG_DATA_W-1:0] with_junk(int w, logic [CFG_DATA_W-1:0] v);
        logic [CFG_DATA_W-1:0] mask;
        mask = (CFG_DATA_W'(1) << w) - 1'b1;
        if ($urandom_range(0, 3) != 0) return v & mask;
        return (CFG_DATA_W'($urandom) & ~mask) | (v & mask);
    endfunction

    // One trial/start beat. Valid is lowered only for a gap, so back-to-back
    // beats keep it high with one assignment per step.
    task automatic send_beat(logic kind, logic [SPK_W-1:0] spikes,
                             bit typed = 1'b0, t_result want = '0);
        t_result got;
        hush = rand_on && (beats_sent - rand_base >= QUIET_FROM)
                       && (beats_sent - rand_base < QUIET_TO);
        cfg_if.valid <= 1'b0;
        while (!hush && $urandom_range(0, 99) < IDLE_PCT) begin
            trial_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        trial_if.valid       <= 1'b1;
        trial_if.kind        <= kind;
        trial_if.spike_count <= spikes;
        do @(posedge i_clk); while (!trial_if.ready);
        got = track_beat(kind, spikes);
        expected_q.insert(expected_q.size(), typed ? want : got);
        beats_sent++;
    endtask

    // Register write, only once every result has drained (tracker idle)
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        trial_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_START_AMP:    cfg_start_amp    = data[AMP_W-1:0];
            REG_START_STEP:   cfg_start_step   = data[STEP_W-1:0];
            REG_FINAL_STEP:   cfg_final_step   = data[STEP_W-1:0];
            REG_MIN_SPIKES:   cfg_min_spikes   = data[SPK_W-1:0];
            REG_REPEAT_LIMIT: cfg_repeat_limit = data[CNT_W-1:0];
            default: ;        // unmapped index: no effect
        endcase
    endtask

    // Result side backpressure
    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            result_if.ready <= hush || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Result checker: every accepted result beat against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got.next_amplitude = result_if.next_amplitude;
            got.step_size      = result_if.step_size;
            got.phase          = result_if.phase;
            got.trial_number   = result_if.trial_number;
            got.spiking_trials = result_if.spiking_trials;
            got.finished       = result_if.finished;
            got.bad_setup      = result_if.bad_setup;
            if (expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: result beat with none expected: amp %0d step %0d phase %0d",
                             $realtime, $signed(got.next_amplitude), got.step_size,
                             got.phase);
            end else begin
                want = expected_q[0];
                expected_q.delete(0);
                if (got.next_amplitude !== want.next_amplitude
                        || got.step_size !== want.step_size
                        || got.phase !== want.phase
                        || got.trial_number !== want.trial_number
                        || got.spiking_trials !== want.spiking_trials
                        || got.finished !== want.finished
                        || got.bad_setup !== want.bad_setup) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("%0t: result mismatch (exp/act)", $realtime);
                        $display("  amp %0d/%0d step %0d/%0d phase %0d/%0d",
                                 $signed(want.next_amplitude), $signed(got.next_amplitude),
                                 want.step_size, got.step_size, want.phase, got.phase);
                        $display("  trials %0d/%0d spiking %0d/%0d finished %0b/%0b bad %0b/%0b",
                                 want.trial_number, got.trial_number,
                                 want.spiking_trials, got.spiking_trials,
                                 want.finished, got.finished, want.bad_setup, got.bad_setup);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] pick;
        longint                thr_amp;
        logic                  kind;
        logic [SPK_W-1:0]      spikes;
        int                    roll;
        int                    n_trials;
        int                    halted;
        int                    t;

        trial_if.valid       <= 1'b0;
        trial_if.kind        <= KIND_START;
        trial_if.spike_count <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= REG_START_AMP;
        cfg_if.data          <= '0;
        i_rst_n              <= 1'b0;

        cfg_start_amp    = RST_START_AMP;
        cfg_start_step   = RST_START_STEP;
        cfg_final_step   = RST_FINAL_STEP;
        cfg_min_spikes   = RST_MIN_SPIKES;
        cfg_repeat_limit = RST_REPEAT_LIMIT;
        trk_amp          = '0;
        trk_step         = '0;
        trk_phase        = PH_SEARCH;
        trk_last_above   = 1'b0;
        trk_have_last    = 1'b0;
        trk_trials       = '0;
        trk_spiking      = '0;
        trk_done         = 1'b0;
        trk_bad          = 1'b0;

        // -- Directed plan --------------------------------------------------
        // Reset registers. Trials before any start run with a zero step; the
        // second one reverses at step 0 <= final, so it jumps to confirm.
        plan_beat(KIND_TRIAL, '0, 1'b1,
                  result_of('0, '0, PH_SEARCH, CNT_W'(1), '0, 1'b0, 1'b0));
        plan_beat(KIND_TRIAL, SPK_MAX, 1'b1,
                  result_of('0, RST_FINAL_STEP, PH_CONFIRM, '0, '0, 1'b0, 1'b0));
        plan_beat(KIND_START, SPK_MAX, 1'b1,
                  result_of(RST_START_AMP, RST_START_STEP, PH_SEARCH, '0, '0, 1'b0, 1'b0));
        plan_beat(KIND_TRIAL, SPK_W'(1), 1'b1,
                  result_of(AMP_W'(-100), RST_START_STEP, PH_SEARCH, CNT_W'(1), CNT_W'(1),
                            1'b0, 1'b0));
        plan_beat(KIND_TRIAL, '0);              // reversal: step 100 refines to 50
        plan_beat(KIND_TRIAL, SPK_W'(3));

        // Top of range: upward trial pins at max, then the widest refine
        plan_reg(REG_START_AMP, AMP_MAX);
        plan_reg(REG_START_STEP, CFG_DATA_W'(STEP_MAX));
        plan_reg(REG_FINAL_STEP, CFG_DATA_W'(1));
        plan_reg(REG_MIN_SPIKES, CFG_DATA_W'(SPK_MAX));
        plan_reg(REG_REPEAT_LIMIT, CFG_DATA_W'(1));
        plan_beat(KIND_START, '0, 1'b1,
                  result_of(AMP_MAX, STEP_MAX, PH_SEARCH, '0, '0, 1'b0, 1'b0));
        plan_beat(KIND_TRIAL, '0, 1'b1,
                  result_of(AMP_MAX, STEP_MAX, PH_SEARCH, CNT_W'(1), '0, 1'b0, 1'b0));
        plan_beat(KIND_TRIAL, SPK_MAX);
        plan_beat(KIND_TRIAL, SPK_MAX - 1'b1);  // spikes but below the minimum

        // Start step below final step: flagged, and trials are frozen
        plan_reg(REG_START_AMP, AMP_MIN);
        plan_reg(REG_START_STEP, CFG_DATA_W'(5));
        plan_reg(REG_FINAL_STEP, CFG_DATA_W'(10));
        plan_beat(KIND_START, '0, 1'b1,
                  result_of(AMP_MIN, STEP_W'(5), PH_SEARCH, '0, '0, 1'b0, 1'b1));
        plan_beat(KIND_TRIAL, SPK_MAX, 1'b1,
                  result_of(AMP_MIN, STEP_W'(5), PH_SEARCH, '0, '0, 1'b0, 1'b1));

        // Zero final step, pinned at min, repeat limit zero (never finishes)
        plan_reg(REG_START_STEP, CFG_DATA_W'(7));
        plan_reg(REG_FINAL_STEP, '0);
        plan_reg(REG_MIN_SPIKES, CFG_DATA_W'(1));
        plan_reg(REG_REPEAT_LIMIT, '0);
        plan_beat(KIND_START, '0, 1'b1,
                  result_of(AMP_MIN, STEP_W'(7), PH_SEARCH, '0, '0, 1'b0, 1'b0));
        plan_beat(KIND_TRIAL, SPK_W'(1), 1'b1,
                  result_of(AMP_MIN, STEP_W'(7), PH_SEARCH, CNT_W'(1), CNT_W'(1), 1'b0, 1'b0));
        plan_beat(KIND_TRIAL, '0);              // refine to zero
        plan_beat(KIND_TRIAL, SPK_W'(1));       // to confirm
        plan_beat(KIND_TRIAL, '0);
        plan_beat(KIND_TRIAL, SPK_W'(1));       // to record

        // Full walk to finished with a limit of one, then a frozen trial
        plan_reg(REG_START_AMP, '0);
        plan_reg(REG_START_STEP, CFG_DATA_W'(10));
        plan_reg(REG_FINAL_STEP, CFG_DATA_W'(10));
        plan_reg(REG_REPEAT_LIMIT, CFG_DATA_W'(1));
        plan_beat(KIND_START, SPK_W'(5));
        plan_beat(KIND_TRIAL, SPK_W'(1));
        plan_beat(KIND_TRIAL, '0);
        plan_beat(KIND_TRIAL, SPK_W'(1));
        plan_beat(KIND_TRIAL, '0);
        plan_beat(KIND_TRIAL, SPK_W'(1), 1'b1,
                  result_of(AMP_W'(-10), STEP_W'(10), PH_RECORD, CNT_W'(1), CNT_W'(1),
                            1'b1, 1'b0));
        plan_beat(KIND_TRIAL, '0, 1'b1,
                  result_of(AMP_W'(-10), STEP_W'(10), PH_RECORD, CNT_W'(1), CNT_W'(1),
                            1'b1, 1'b0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].op == ROW_REG)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_beat(plan[i].kind, plan[i].spikes, plan[i].typed, plan[i].want);
        end

        // -- Random sessions ------------------------------------------------
        // Each session: new settings, a start, then trials answered by a
        // simulated cell with a hidden threshold, so the staircase converges
        // through confirm and record. A share of beats is noise or restarts.
        rand_base = beats_sent;
        rand_on   = 1'b1;
        while (beats_sent - rand_base < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 60) begin
                roll = $urandom_range(0, 99);
                if (roll < 5)       pick = '0;
                else if (roll < 10) pick = CFG_DATA_W'(STEP_MAX);
                else if (roll < 20) pick = CFG_DATA_W'($urandom_range(0, STEP_MAX));
                else                pick = CFG_DATA_W'($urandom_range(1, 60));
                write_reg(REG_FINAL_STEP, with_junk(STEP_W, pick));
            end
            if ($urandom_range(0, 99) < 60) begin
                roll = $urandom_range(0, 99);
                if (roll < 8 && cfg_final_step != '0)
                    pick = CFG_DATA_W'($urandom_range(0, cfg_final_step - 1'b1));
                else if (roll < 16) pick = CFG_DATA_W'(STEP_MAX);
                else if (roll < 28) pick = CFG_DATA_W'($urandom_range(0, STEP_MAX));
                else                pick = CFG_DATA_W'($urandom_range(1, 2000));
                write_reg(REG_START_STEP, with_junk(STEP_W, pick));
            end
            if ($urandom_range(0, 99) < 60) begin
                roll = $urandom_range(0, 99);
                if (roll < 10)      pick = AMP_MAX;
                else if (roll < 20) pick = AMP_MIN;
                else if (roll < 35) pick = CFG_DATA_W'($urandom);
                else                pick = CFG_DATA_W'(longint'($urandom_range(0, 10000)) - 5000);
                write_reg(REG_START_AMP, pick);
            end
            if ($urandom_range(0, 99) < 60) begin
                roll = $urandom_range(0, 99);
                if (roll < 10)      pick = '0;
                else if (roll < 20) pick = CFG_DATA_W'(SPK_MAX);
                else if (roll < 35) pick = CFG_DATA_W'($urandom_range(0, SPK_MAX));
                else                pick = CFG_DATA_W'($urandom_range(1, 8));
                write_reg(REG_MIN_SPIKES, with_junk(SPK_W, pick));
            end
            if ($urandom_range(0, 99) < 60) begin
                roll = $urandom_range(0, 99);
                if (roll < 10)      pick = '0;
                else if (roll < 15) pick = CFG_DATA_W'(CNT_MAX);
                else                pick = CFG_DATA_W'($urandom_range(1, 25));
                write_reg(REG_REPEAT_LIMIT, with_junk(CNT_W, pick));
            end
            if ($urandom_range(0, 99) < 5)
                write_reg(CFG_IDX_W'($urandom_range(REG_REPEAT_LIMIT + 1, IDX_TOP)),
                          CFG_DATA_W'($urandom));

            thr_amp = longint'(cfg_start_amp) + longint'($urandom_range(0, 6000)) - 3000;
            send_beat(KIND_START, SPK_W'($urandom_range(0, SPK_MAX)));

            n_trials = $urandom_range(20, 90);
            halted   = 0;
            for (t = 0; t < n_trials && halted < 3
                    && beats_sent - rand_base < RANDOM_ITEMS; t++) begin
                roll = $urandom_range(0, 99);
                kind = KIND_TRIAL;
                if (roll < 3) begin
                    kind   = KIND_START;     // restart mid-run
                    spikes = SPK_W'($urandom_range(0, SPK_MAX));
                end else if (roll < 12) begin
                    spikes = SPK_W'($urandom_range(0, SPK_MAX));
                end else if (longint'(trk_amp) >= thr_amp) begin
                    spikes = SPK_W'($urandom_range(cfg_min_spikes, SPK_MAX));
                end else if (cfg_min_spikes == '0) begin
                    spikes = SPK_W'($urandom_range(0, SPK_MAX));
                end else begin
                    spikes = SPK_W'($urandom_range(0, cfg_min_spikes - 1'b1));
                end
                send_beat(kind, spikes);
                if (trk_done || trk_bad) halted++;
            end
        end
        rand_on = 1'b0;

        // -- Drain and verdict ----------------------------------------------
        trial_if.valid <= 1'b0;
        cfg_if.valid   <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
